FILE: rtl/wrcr_pkg.sv
// ----------------------------------------------------------------------------
// wrcr_pkg: shared constants, types and helpers
// Fixed-point constants, the arctangent table and saturation helpers for the
// rolling-wheel constraint row pipeline.
// ----------------------------------------------------------------------------
package wrcr_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int AtanLen = 30;

	// register indexes on the configuration channel
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_STATIC  = 2'd1;
	localparam logic [1:0] REG_DYNAMIC = 2'd2;

	localparam logic [30:0] RADIUS_RST  = 31'd65536;
	localparam logic [30:0] STATIC_RST  = 31'd65536;
	localparam logic [30:0] DYNAMIC_RST = 31'd32768;

	// angle constants in Q30
	localparam logic signed [47:0] TWO_PI_Q30      = 48'sd6746518852;
	localparam logic signed [35:0] TWO_PI_Q30_N    = 36'sd6746518852;
	localparam logic signed [35:0] PI_Q30          = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_LESS_HP  = 36'sd5059889139;
	localparam logic signed [33:0] GAIN_Q30        = 34'sd652032874;

	// floor(2^46 / 2pi_q30): quotient estimate is within one of the true value
	localparam logic signed [15:0] RECIP_TWO_PI = 16'((64'd1 << 46) / 64'd6746518852);

	localparam logic [64:0] HALF_SQ_Q32 = 65'd2147483648;

	typedef struct packed {
		logic signed [31:0] rate;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] sr;
		logic        [30:0] lim_s;
		logic        [30:0] lim_d;
		logic               neg;
	} side_t;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
		logic signed [35:0] v;
		unique case (idx)
			5'd0:  v = 36'sd843314856;
			5'd1:  v = 36'sd497837829;
			5'd2:  v = 36'sd263043836;
			5'd3:  v = 36'sd133525158;
			5'd4:  v = 36'sd67021686;
			5'd5:  v = 36'sd33543515;
			5'd6:  v = 36'sd16775850;
			5'd7:  v = 36'sd8388437;
			5'd8:  v = 36'sd4194282;
			5'd9:  v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			5'd24: v = 36'sd63;
			5'd25: v = 36'sd31;
			5'd26: v = 36'sd15;
			5'd27: v = 36'sd7;
			5'd28: v = 36'sd3;
			5'd29: v = 36'sd1;
			default: v = 36'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// product of two non-negative Q16.16 values, clamped to 31 bits
	function automatic logic [30:0] sat31u(input logic [61:0] p);
		logic [45:0] s;
		s = p[61:16];
		return (s > 46'd2147483647) ? 31'h7fffffff : s[30:0];
	endfunction

endpackage

FILE: rtl/wheel_rolling_constraint_rows.sv
// ----------------------------------------------------------------------------
// wheel_rolling_constraint_rows
// Evaluates one rolling-wheel constraint row per word: heading cos/sin by a
// pipelined CORDIC, direction rate, contact speed test and friction limits.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata: heading_angle, heading_rate, wheel_vel_x,
//           |           |        wheel_vel_y, wheel_spin_rate
//  m_*      | out       | tdata: dir_x .. upper_limit, tuser: sliding_flag
//  cfg_*    | in        | cfg_index, cfg_data (low 31 bits kept)
//
// one word per cycle while the output is not stalled; 4 angle reduction stages,
// one stage per cordic step (at most 30 steps), 5 product and limit stages.
// each stage moves on when the stage after it is empty or moving, so bubbles
// close up under an output stall and nothing is lost or repeated.
// reset clears all stage valid bits and loads the register defaults.
module wheel_rolling_constraint_rows #(
	parameter int CORDIC_STEPS = wrcr_pkg::CordicStepsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// heading_angle, heading_rate, wheel_vel_x, wheel_vel_y, wheel_spin_rate
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// dir_x, dir_y, dir_rate_x, dir_rate_y, lower_limit, upper_limit, zero fill
	output logic [167:0] m_tdata,
	// sliding_flag
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int N = (CORDIC_STEPS < wrcr_pkg::AtanLen) ? CORDIC_STEPS
		: wrcr_pkg::AtanLen;
	localparam int SA = N + 5;
	localparam int SB = N + 6;
	localparam int SC = N + 7;
	localparam int SD = N + 8;
	localparam int SE = N + 9;

	logic [30:0] radius_q, static_q, dynamic_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= wrcr_pkg::RADIUS_RST;
			static_q  <= wrcr_pkg::STATIC_RST;
			dynamic_q <= wrcr_pkg::DYNAMIC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wrcr_pkg::REG_RADIUS:  radius_q  <= cfg_data[30:0];
				wrcr_pkg::REG_STATIC:  static_q  <= cfg_data[30:0];
				wrcr_pkg::REG_DYNAMIC: dynamic_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage advance
	logic [SE:1]   vld_q;
	logic [SE+1:1] rdy;

	always_comb begin
		rdy[SE+1] = m_tready;
		for (int k = SE; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= SE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[SE];

	// stage 1: quotient product and raw register products
	logic signed [31:0] in_ang, in_rate, in_vx, in_vy, in_spin;
	assign in_ang  = s_tdata[31:0];
	assign in_rate = s_tdata[63:32];
	assign in_vx   = s_tdata[95:64];
	assign in_vy   = s_tdata[127:96];
	assign in_spin = s_tdata[159:128];

	logic signed [31:0] ang_s1, rate_s1, vx_s1, vy_s1;
	logic signed [47:0] qp_s1;
	logic signed [63:0] srp_s1;
	logic        [61:0] lsp_s1, ldp_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			ang_s1  <= in_ang;
			rate_s1 <= in_rate;
			vx_s1   <= in_vx;
			vy_s1   <= in_vy;
			qp_s1   <= 48'(in_ang) * 48'(wrcr_pkg::RECIP_TWO_PI);
			srp_s1  <= 64'(in_spin) * 64'(signed'({1'b0, radius_q}));
			lsp_s1  <= 62'(static_q) * 62'(radius_q);
			ldp_s1  <= 62'(dynamic_q) * 62'(radius_q);
		end
	end

	// stage 2: remainder estimate, saturate register products
	logic signed [47:0] r_s2;
	wrcr_pkg::side_t    side_s2;
	logic signed [13:0] qe;
	logic signed [15:0] qp_hi;
	assign qp_hi = qp_s1[47:32];
	assign qe = qp_hi[13:0];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			r_s2 <= (48'(ang_s1) <<< 14) - 48'(qe) * wrcr_pkg::TWO_PI_Q30;
			side_s2.rate  <= rate_s1;
			side_s2.vx    <= vx_s1;
			side_s2.vy    <= vy_s1;
			side_s2.sr    <= wrcr_pkg::sat32(64'(srp_s1 >>> 16));
			side_s2.lim_s <= wrcr_pkg::sat31u(lsp_s1);
			side_s2.lim_d <= wrcr_pkg::sat31u(ldp_s1);
			side_s2.neg   <= 1'b0;
		end
	end

	// stage 3: correct the remainder into [0, 2pi)
	logic signed [35:0] r0_s3;
	wrcr_pkg::side_t    side_s3;
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			if (r_s2 < 0) begin
				r0_s3 <= 36'(r_s2 + wrcr_pkg::TWO_PI_Q30);
			end else if (r_s2 >= wrcr_pkg::TWO_PI_Q30) begin
				r0_s3 <= 36'(r_s2 - wrcr_pkg::TWO_PI_Q30);
			end else begin
				r0_s3 <= r_s2[35:0];
			end
			side_s3 <= side_s2;
		end
	end

	// stage 4 onward: cordic, entry j holds the vector after j steps
	logic signed [33:0] cx_s [0:N];
	logic signed [33:0] cy_s [0:N];
	logic signed [35:0] cz_s [0:N];
	wrcr_pkg::side_t    cside_s [0:N];

	// wrap to (-pi, pi] and fold into [-pi/2, pi/2]
	logic signed [35:0] fold_z;
	wrcr_pkg::side_t    fold_side;
	always_comb begin
		fold_side = side_s3;
		priority if (r0_s3 <= wrcr_pkg::HALF_PI_Q30) begin
			fold_z = r0_s3;
			fold_side.neg = 1'b0;
		end else if (r0_s3 < wrcr_pkg::TWO_PI_LESS_HP) begin
			fold_z = r0_s3 - wrcr_pkg::PI_Q30;
			fold_side.neg = 1'b1;
		end else begin
			fold_z = r0_s3 - wrcr_pkg::TWO_PI_Q30_N;
			fold_side.neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			cx_s[0] <= wrcr_pkg::GAIN_Q30;
			cy_s[0] <= '0;
			cz_s[0] <= fold_z;
			cside_s[0] <= fold_side;
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic signed [35:0] ATAN = wrcr_pkg::atan_q30(5'(j));
		always_ff @(posedge clk) begin
			if (rdy[5+j]) begin
				if (cz_s[j] >= 0) begin
					cx_s[j+1] <= cx_s[j] - (cy_s[j] >>> j);
					cy_s[j+1] <= cy_s[j] + (cx_s[j] >>> j);
					cz_s[j+1] <= cz_s[j] - ATAN;
				end else begin
					cx_s[j+1] <= cx_s[j] + (cy_s[j] >>> j);
					cy_s[j+1] <= cy_s[j] - (cx_s[j] >>> j);
					cz_s[j+1] <= cz_s[j] + ATAN;
				end
				cside_s[j+1] <= cside_s[j];
			end
		end
	end

	// stage a: undo fold, round to Q16.16, clamp
	logic signed [33:0] xn, yn, xr, yr;
	assign xn = cside_s[N].neg ? -cx_s[N] : cx_s[N];
	assign yn = cside_s[N].neg ? -cy_s[N] : cy_s[N];
	assign xr = (xn + 34'sd8192) >>> 14;
	assign yr = (yn + 34'sd8192) >>> 14;

	logic signed [17:0] c_sa, s_sa;
	wrcr_pkg::side_t    side_sa;
	always_ff @(posedge clk) begin
		if (rdy[SA]) begin
			c_sa <= (xr > 34'sd65536) ? 18'sd65536 : (xr < -34'sd65536) ? -18'sd65536 : xr[17:0];
			s_sa <= (yr > 34'sd65536) ? 18'sd65536 : (yr < -34'sd65536) ? -18'sd65536 : yr[17:0];
			side_sa <= cside_s[N];
		end
	end

	// stage b: direction products
	logic signed [18:0] ns;
	assign ns = -19'(s_sa);

	logic signed [17:0] c_sb, s_sb;
	logic signed [50:0] prx_sb;
	logic signed [49:0] pry_sb, pcx_sb, pcy_sb;
	wrcr_pkg::side_t    side_sb;
	always_ff @(posedge clk) begin
		if (rdy[SB]) begin
			c_sb   <= c_sa;
			s_sb   <= s_sa;
			prx_sb <= 51'(ns) * 51'(side_sa.rate);
			pry_sb <= 50'(c_sa) * 50'(side_sa.rate);
			pcx_sb <= 50'(c_sa) * 50'(side_sa.sr);
			pcy_sb <= 50'(s_sa) * 50'(side_sa.sr);
			side_sb <= side_sa;
		end
	end

	// stage c: scale, saturate, add wheel velocity
	logic signed [31:0] pcx_sat, pcy_sat;
	assign pcx_sat = wrcr_pkg::sat32(64'(pcx_sb >>> 16));
	assign pcy_sat = wrcr_pkg::sat32(64'(pcy_sb >>> 16));

	logic signed [17:0] c_sc, s_sc;
	logic signed [31:0] rx_sc, ry_sc, cvx_sc, cvy_sc;
	logic        [30:0] lims_sc, limd_sc;
	always_ff @(posedge clk) begin
		if (rdy[SC]) begin
			c_sc    <= c_sb;
			s_sc    <= s_sb;
			rx_sc   <= wrcr_pkg::sat32(64'(prx_sb >>> 16));
			ry_sc   <= wrcr_pkg::sat32(64'(pry_sb >>> 16));
			cvx_sc  <= wrcr_pkg::sat32(64'(pcx_sat) + 64'(side_sb.vx));
			cvy_sc  <= wrcr_pkg::sat32(64'(pcy_sat) + 64'(side_sb.vy));
			lims_sc <= side_sb.lim_s;
			limd_sc <= side_sb.lim_d;
		end
	end

	// stage d: squared contact speed components
	logic signed [32:0] tx, ty;
	logic        [31:0] ax, ay;
	assign tx = cvx_sc[31] ? -33'(cvx_sc) : 33'(cvx_sc);
	assign ty = cvy_sc[31] ? -33'(cvy_sc) : 33'(cvy_sc);
	assign ax = tx[31:0];
	assign ay = ty[31:0];

	logic signed [17:0] c_sd, s_sd;
	logic signed [31:0] rx_sd, ry_sd;
	logic        [63:0] sqx_sd, sqy_sd;
	logic        [30:0] lims_sd, limd_sd;
	always_ff @(posedge clk) begin
		if (rdy[SD]) begin
			c_sd    <= c_sc;
			s_sd    <= s_sc;
			rx_sd   <= rx_sc;
			ry_sd   <= ry_sc;
			sqx_sd  <= 64'(ax) * 64'(ax);
			sqy_sd  <= 64'(ay) * 64'(ay);
			lims_sd <= lims_sc;
			limd_sd <= limd_sc;
		end
	end

	// stage e: speed test, limit select, output register
	logic        slide;
	logic [30:0] lim;
	assign slide = (65'(sqx_sd) + 65'(sqy_sd)) > wrcr_pkg::HALF_SQ_Q32;
	assign lim   = slide ? limd_sd : lims_sd;

	logic signed [17:0] c_se, s_se;
	logic signed [31:0] rx_se, ry_se, lo_se;
	logic        [30:0] hi_se;
	logic               slide_se;
	always_ff @(posedge clk) begin
		if (rdy[SE]) begin
			c_se     <= c_sd;
			s_se     <= s_sd;
			rx_se    <= rx_sd;
			ry_se    <= ry_sd;
			lo_se    <= 32'(-33'({2'b00, lim}));
			hi_se    <= lim;
			slide_se <= slide;
		end
	end

	assign m_tdata = {5'd0, hi_se, lo_se, ry_se, rx_se, s_se, c_se};
	assign m_tuser = slide_se;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: rolling-wheel constraint row pipeline
// Streams directed and random rows through the block and compares each output
// word with a predictor. The register settings change between phases, and
// both stream sides idle at random.
// ----------------------------------------------------------------------------
class row_scoreboard;

	typedef struct {
		longint dir_x;
		longint dir_y;
		longint rate_x;
		longint rate_y;
		longint lower;
		longint upper;
		bit     sliding;
	} row_t;

	localparam longint TwoPi = 64'sd6746518852;
	localparam longint Pi = 64'sd3373259426;
	localparam longint HalfPi = 64'sd1686629713;
	localparam longint Gain = 64'sd652032874;
	localparam int Steps = 16;

	longint atan_tbl[30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1
	};

	longint radius = 65536;
	longint fric_static = 65536;
	longint fric_dynamic = 32768;
	row_t   pending_rows[$];
	int     errors = 0;
	int     rows_checked = 0;
	int     rows_sliding = 0;

	function void write_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			wrcr_pkg::REG_RADIUS:  radius = data[30:0];
			wrcr_pkg::REG_STATIC:  fric_static = data[30:0];
			wrcr_pkg::REG_DYNAMIC: fric_dynamic = data[30:0];
			default: ;
		endcase
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function longint fx_mul(longint a, longint b);
		return clip32((a * b) >>> 16);
	endfunction

	function void heading_cos_sin(longint ang, output longint c, output longint s);
		longint r, x, y, dx, dy;
		bit     flip;
		r = (ang * 16384) % TwoPi;
		flip = 0;
		x = Gain;
		y = 0;
		if (r < 0) r += TwoPi;
		if (r > Pi) r -= TwoPi;
		if (r > HalfPi) begin
			r -= Pi;
			flip = 1;
		end else if (r < -HalfPi) begin
			r += Pi;
			flip = 1;
		end
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx; y += dy; r -= atan_tbl[i];
			end else begin
				x += dx; y -= dy; r += atan_tbl[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		x = (x + 8192) >>> 14;
		y = (y + 8192) >>> 14;
		c = (x > 65536) ? 65536 : (x < -65536) ? -65536 : x;
		s = (y > 65536) ? 65536 : (y < -65536) ? -65536 : y;
	endfunction

	function void note_row(logic [159:0] d);
		row_t   e;
		longint rate, vx, vy, spin, c, s, sr, cvx, cvy, lim;
		longint unsigned ax, ay;
		rate = longint'($signed(d[63:32]));
		vx = longint'($signed(d[95:64]));
		vy = longint'($signed(d[127:96]));
		spin = longint'($signed(d[159:128]));
		heading_cos_sin(longint'($signed(d[31:0])), c, s);
		sr = fx_mul(spin, radius);
		cvx = clip32(fx_mul(sr, c) + vx);
		cvy = clip32(fx_mul(sr, s) + vy);
		ax = (cvx < 0) ? -cvx : cvx;
		ay = (cvy < 0) ? -cvy : cvy;
		e.sliding = (ax * ax + ay * ay) > 64'd2147483648;
		lim = fx_mul(e.sliding ? fric_dynamic : fric_static, radius);
		if (lim < 0) lim = 0;
		e.dir_x = c;
		e.dir_y = s;
		e.rate_x = fx_mul(-s, rate);
		e.rate_y = fx_mul(c, rate);
		e.lower = -lim;
		e.upper = lim;
		pending_rows.push_back(e);
	endfunction

	function void compare(string name, longint want, longint got, int width);
		logic [63:0] mask;
		mask = (64'd1 << width) - 1;
		if ((want & mask) != (got & mask)) begin
			$error("%s: expected %h, actual %h", name, want & mask, got & mask);
			errors++;
		end
	endfunction

	function void check_row(logic [167:0] d, logic flag);
		row_t e;
		if (pending_rows.size() == 0) begin
			$error("output word with no row pending");
			errors++;
			return;
		end
		e = pending_rows.pop_front();
		compare("dir_x", e.dir_x, d[17:0], 18);
		compare("dir_y", e.dir_y, d[35:18], 18);
		compare("dir_rate_x", e.rate_x, d[67:36], 32);
		compare("dir_rate_y", e.rate_y, d[99:68], 32);
		compare("lower_limit", e.lower, d[131:100], 32);
		compare("upper_limit", e.upper, d[162:132], 31);
		compare("zero_fill", 0, d[167:163], 5);
		compare("sliding_flag", e.sliding, flag, 1);
		rows_checked++;
		if (flag) rows_sliding++;
	endfunction

endclass

module testbench;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [167:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	row_scoreboard rows = new();
	bit  steady = 0;
	int  hold_cycles = 0;
	int  phase_count = 0;

	wheel_rolling_constraint_rows u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) rows.check_row(m_tdata, m_tuser);
	end

	// sink side: random stalls, with a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || $urandom_range(99) >= 6;
			end
		end
	end

	task automatic send_row(logic [159:0] d);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		rows.note_row(d);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		rows.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (rows.pending_rows.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] signed_near(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic logic [159:0] random_row();
		logic [31:0] ang, rate, vx, vy, spin;
		case ($urandom_range(3))
			0: ang = $urandom;
			1: ang = signed_near(823550);
			default: ang = signed_near(8) * 102944 + signed_near(4);
		endcase
		rate = $urandom_range(1) ? $urandom : signed_near(1 << 20);
		if ($urandom_range(2) == 0) begin
			vx = $urandom; vy = $urandom;
		end else begin
			vx = signed_near(70000); vy = signed_near(70000);
		end
		case ($urandom_range(3))
			0: spin = $urandom;
			1: spin = 0;
			default: spin = signed_near(1 << 16);
		endcase
		return {spin, vy, vx, rate, ang};
	endfunction

	task automatic run_phase(logic [31:0] rad, logic [31:0] fs, logic [31:0] fd, int n);
		write_cfg(wrcr_pkg::REG_RADIUS, {1'($urandom_range(1)), rad[30:0]});
		write_cfg(wrcr_pkg::REG_STATIC, {1'($urandom_range(1)), fs[30:0]});
		write_cfg(wrcr_pkg::REG_DYNAMIC, {1'($urandom_range(1)), fd[30:0]});
		write_cfg(2'd3, $urandom);
		for (int i = 0; i < n; i++) send_row(random_row());
		drain();
		phase_count++;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: angle extremes, quadrant edges, threshold of contact speed
		send_row({32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		send_row({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
		send_row({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
		send_row({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd102944});
		send_row({32'd0, 32'd0, 32'd46341, 32'h00010000, 32'd205887});
		send_row({32'd0, 32'd0, 32'd46340, 32'hffff0000, -32'd205887});
		send_row({32'd0, 32'd46341, 32'd0, 32'd65536, -32'd102944});
		send_row({32'd0, -32'd46340, 32'd0, 32'h7fffffff, 32'd411775});
		send_row({32'd65536, 32'd0, 32'd0, 32'h80000000, 32'd1});
		send_row({32'h80000000, 32'd0, 32'd0, 32'd65536, 32'hffffffff});
		send_row({32'd1, 32'd1, 32'd1, 32'd1, 32'd308831});
		send_row({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, -32'd308831});
		send_row({32'd0, 32'd0, -32'd46341, 32'd0, 32'd51472});
		send_row({32'd0, 32'd0, 32'd0, 32'd0, 32'd154416});
		drain();

		run_phase(32'd65536, 32'd65536, 32'd32768, 270);
		steady = 1;
		run_phase(32'h7fffffff, 32'h7fffffff, 32'd0, 270);
		steady = 0;
		hold_cycles = 300;
		run_phase(32'd0, 32'd5, 32'd7, 270);
		run_phase($urandom, $urandom, $urandom, 270);
		run_phase(32'd196608, 32'h7fffffff, 32'd1, 270);
		run_phase(32'd1, 32'd0, 32'h7fffffff, 270);

		repeat (40) @(posedge clk);
		$display("covered %0d rows over %0d register settings, %0d of them sliding",
			rows.rows_checked, phase_count + 1, rows.rows_sliding);
		if (rows.errors == 0 && rows.pending_rows.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
